// ----- hdl/scsi_controller_register_model_unit_macros.svh -----
// assertion macros for the scsi controller register model unit
// no dependencies; included by the modules that carry assertions
`ifndef SCSI_CONTROLLER_REGISTER_MODEL_UNIT_MACROS_SVH
`define SCSI_CONTROLLER_REGISTER_MODEL_UNIT_MACROS_SVH
`ifndef SYNTH
// plain check on every clock edge outside reset
`define SCU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// check on the clock after a trigger
`define SCU_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SCU_ASSERT(lbl, prop, msg)
`define SCU_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ----- hdl/scu_pkg.sv -----
// shared types and constants for the scsi controller register model unit
// no dependencies; used by the interfaces, the core and the top level
package scu_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int CDB_BYTES  = 12;
    localparam int REG_COUNT  = 16;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int REG_IDX_W  = $clog2(REG_COUNT);
    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int LBA_W      = 32;

    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(FIFO_DEPTH - 1);

    typedef logic [BYTE_W-1:0] byte_t;

    // access kinds
    localparam logic [KIND_W-1:0] KIND_READ     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DMA_DONE = 2'd2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] R_XLO    = 4'd0;
    localparam logic [REG_IDX_W-1:0] R_XMID   = 4'd1;
    localparam logic [REG_IDX_W-1:0] R_FIFO   = 4'd2;
    localparam logic [REG_IDX_W-1:0] R_CMD    = 4'd3;
    localparam logic [REG_IDX_W-1:0] R_STATUS = 4'd4;
    localparam logic [REG_IDX_W-1:0] R_IRQ    = 4'd5;
    localparam logic [REG_IDX_W-1:0] R_INT    = 4'd6;
    localparam logic [REG_IDX_W-1:0] R_FIFOST = 4'd7;
    localparam logic [REG_IDX_W-1:0] R_XHI    = 4'd14;

    // command codes, low seven bits of the command byte
    localparam logic [6:0] CMD_NOP        = 7'h00;
    localparam logic [6:0] CMD_CHIP_RESET = 7'h02;
    localparam logic [6:0] CMD_BUS_RESET  = 7'h03;
    localparam logic [6:0] CMD_XFER_INFO  = 7'h10;
    localparam logic [6:0] CMD_ICCS       = 7'h11;
    localparam logic [6:0] CMD_MSG_ACCEPT = 7'h12;
    localparam logic [6:0] CMD_SEL_ATN    = 7'h42;
    localparam int         CMD_DMA_BIT    = 7;

    // identify bytes seen ahead of the cdb
    localparam byte_t ID_NONE  = 8'h00;
    localparam byte_t ID_MSG_0 = 8'h48;
    localparam byte_t ID_MSG_1 = 8'h4B;

    // cdb opcodes
    localparam byte_t OP_REQ_SENSE  = 8'h03;
    localparam byte_t OP_INQUIRY    = 8'h12;
    localparam byte_t OP_MODE_SENSE = 8'h1A;
    localparam byte_t OP_READ_TOC   = 8'h43;
    localparam byte_t OP_MODE_SEL   = 8'h15;
    localparam byte_t OP_READ10     = 8'h28;

    // bus phases in status bits 2..0
    localparam logic [2:0] PH_DATA_OUT = 3'd0;
    localparam logic [2:0] PH_DATA_IN  = 3'd1;
    localparam logic [2:0] PH_STATUS   = 3'd3;

    // status masks
    localparam byte_t ST_CLR_IRQ   = 8'h7F;
    localparam byte_t ST_CLR_CNT   = 8'hEF;
    localparam byte_t ST_CLR_PHASE = 8'hF8;
    localparam byte_t ST_KEEP_XFER = 8'h78;
    localparam byte_t ST_IRQ       = 8'h80;

    // register values set by commands
    localparam byte_t IRQ_RESET   = 8'h08;
    localparam byte_t INT_IDLE    = 8'h00;
    localparam byte_t INT_STEP4   = 8'h04;
    localparam byte_t INT_STEP6   = 8'h06;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [REG_IDX_W-1:0] reg_index;
        byte_t                write_data;
    } scu_item_t;

    typedef struct packed {
        byte_t             read_data;
        logic              irq_raise;
        byte_t             cmd_opcode;
        logic [LBA_W-1:0]  sector_lba;
        logic              read_pending;
    } scu_result_t;

endpackage

// ----- hdl/scu_in_if.sv -----
// request channel carrying one register access per transfer
// depends on scu_pkg for field widths
interface scu_in_if import scu_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [REG_IDX_W-1:0] reg_index;
    byte_t                write_data;

    modport source (output valid, output kind, output reg_index, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input reg_index, input write_data,
                    output ready);
endinterface

// ----- hdl/scu_out_if.sv -----
// response channel carrying one result per transfer
// depends on scu_pkg for field widths
interface scu_out_if import scu_pkg::*;;
    logic             valid;
    logic             ready;
    byte_t            read_data;
    logic             irq_raise;
    byte_t            cmd_opcode;
    logic [LBA_W-1:0] sector_lba;
    logic             read_pending;

    modport source (output valid, output read_data, output irq_raise, output cmd_opcode,
                    output sector_lba, output read_pending, input ready);
    modport sink   (input valid, input read_data, input irq_raise, input cmd_opcode,
                    input sector_lba, input read_pending, output ready);
endinterface

// ----- hdl/scu_core.sv -----
// register file, fifo, cdb latch and command decode of the controller
// depends on scu_pkg and the assertion macro header
`include "scsi_controller_register_model_unit_macros.svh"

module scu_core import scu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  scu_item_t   item,
    output scu_result_t result
);

    byte_t            reg_file_reg  [REG_COUNT];
    byte_t            reg_file_next [REG_COUNT];
    byte_t            fifo_reg      [FIFO_DEPTH];
    byte_t            fifo_next     [FIFO_DEPTH];
    byte_t            cdb_reg       [CDB_BYTES];
    byte_t            cdb_next      [CDB_BYTES];
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [LBA_W-1:0] lba_reg;
    logic [LBA_W-1:0] lba_next;
    logic             rflag_reg;
    logic             rflag_next;

    logic [REG_IDX_W-1:0] r;
    byte_t                v;
    logic [6:0]           op;
    byte_t                first;
    byte_t                rd;
    logic                 irq;

    assign r     = item.reg_index;
    assign v     = item.write_data;
    assign op    = item.write_data[6:0];
    assign first = fifo_reg[1];

    always_comb
    begin
        reg_file_next = reg_file_reg;
        fifo_next     = fifo_reg;
        cdb_next      = cdb_reg;
        ptr_next      = ptr_reg;
        lba_next      = lba_reg;
        rflag_next    = rflag_reg;
        rd            = '0;
        irq           = 1'b0;
        if (go)
        begin
            case (item.kind)
                KIND_READ:
                begin
                    if (r != R_FIFO)
                    begin
                        rd = reg_file_reg[r];
                    end
                    // reading the irq register acknowledges the interrupt
                    if (r == R_IRQ)
                    begin
                        reg_file_next[R_STATUS] = reg_file_reg[R_STATUS] & ST_CLR_IRQ;
                    end
                end
                KIND_WRITE:
                begin
                    if (r == R_XLO || r == R_XMID || r == R_XHI)
                    begin
                        reg_file_next[R_STATUS] = reg_file_reg[R_STATUS] & ST_CLR_CNT;
                    end
                    if (r == R_FIFO)
                    begin
                        // pointer saturates, so a full fifo keeps overwriting the last entry
                        fifo_next[ptr_reg] = v;
                        if (ptr_reg != PTR_MAX)
                        begin
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end
                    if (r == R_CMD)
                    begin
                        ptr_next = '0;
                        case (op)
                            CMD_NOP:
                            begin
                                reg_file_next[R_IRQ] = IRQ_RESET;
                            end
                            CMD_CHIP_RESET:
                            begin
                                reg_file_next[R_IRQ]    = IRQ_RESET;
                                reg_file_next[R_STATUS] = reg_file_reg[R_STATUS] | ST_IRQ;
                                irq = 1'b1;
                            end
                            CMD_BUS_RESET:
                            begin
                                reg_file_next[R_INT] = INT_STEP4;
                                irq = 1'b1;
                            end
                            CMD_SEL_ATN:
                            begin
                                if (first == ID_NONE || first == ID_MSG_0 || first == ID_MSG_1)
                                begin
                                    reg_file_next[R_INT] = INT_STEP6;
                                end
                                else
                                begin
                                    reg_file_next[R_INT] = INT_STEP4;
                                end
                                for (int i = 0; i < CDB_BYTES; i++)
                                begin
                                    cdb_next[i] = fifo_reg[PTR_W'(i + 1)];
                                end
                                rflag_next = 1'b0;
                                case (first)
                                    OP_REQ_SENSE, OP_INQUIRY, OP_MODE_SENSE, OP_READ_TOC:
                                    begin
                                        reg_file_next[R_STATUS][2:0] = PH_DATA_IN;
                                    end
                                    OP_MODE_SEL:
                                    begin
                                        reg_file_next[R_STATUS][2:0] = PH_DATA_OUT;
                                    end
                                    OP_READ10:
                                    begin
                                        lba_next = {fifo_reg[3], fifo_reg[4],
                                                    fifo_reg[5], fifo_reg[6]};
                                        rflag_next = 1'b1;
                                        reg_file_next[R_STATUS][2:0] = PH_DATA_IN;
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                                irq = 1'b1;
                            end
                            CMD_XFER_INFO, CMD_ICCS, CMD_MSG_ACCEPT:
                            begin
                                if (op == CMD_XFER_INFO && v[CMD_DMA_BIT])
                                begin
                                    reg_file_next[R_STATUS][2:0] = PH_STATUS;
                                    reg_file_next[R_INT]         = INT_IDLE;
                                    irq = 1'b1;
                                end
                                else
                                begin
                                    // non-dma transfer falls through to message accept
                                    if (op != CMD_MSG_ACCEPT)
                                    begin
                                        irq = 1'b1;
                                        reg_file_next[R_STATUS] =
                                            reg_file_reg[R_STATUS] & ST_KEEP_XFER;
                                    end
                                    reg_file_next[R_STATUS] = reg_file_next[R_STATUS] | ST_IRQ;
                                    reg_file_next[R_INT]    = INT_STEP6;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    if (!(r == R_STATUS || r == R_INT || r == R_IRQ || r == R_FIFOST))
                    begin
                        reg_file_next[r] = v;
                    end
                end
                KIND_DMA_DONE:
                begin
                    reg_file_next[R_STATUS] = reg_file_reg[R_STATUS] & ST_CLR_PHASE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                reg_file_reg[i] <= '0;
            end
            for (int i = 0; i < FIFO_DEPTH; i++)
            begin
                fifo_reg[i] <= '0;
            end
            for (int i = 0; i < CDB_BYTES; i++)
            begin
                cdb_reg[i] <= '0;
            end
            ptr_reg   <= '0;
            lba_reg   <= '0;
            rflag_reg <= 1'b0;
        end
        else
        begin
            reg_file_reg <= reg_file_next;
            fifo_reg     <= fifo_next;
            cdb_reg      <= cdb_next;
            ptr_reg      <= ptr_next;
            lba_reg      <= lba_next;
            rflag_reg    <= rflag_next;
        end
    end

    assign result.read_data    = rd;
    assign result.irq_raise    = irq;
    assign result.cmd_opcode   = cdb_next[0];
    assign result.sector_lba   = lba_next;
    assign result.read_pending = rflag_next;

    `SCU_ASSERT_NEXT(a_ptr_saturates,
        go && item.kind == KIND_WRITE && r == R_FIFO && ptr_reg == PTR_MAX,
        ptr_reg == PTR_MAX, "fifo pointer wrapped past the last entry")
    `SCU_ASSERT_NEXT(a_cmd_clears_ptr, go && item.kind == KIND_WRITE && r == R_CMD,
        ptr_reg == '0, "command write left the fifo pointer set")
    `SCU_ASSERT(a_read_flag_opcode, !rflag_reg || cdb_reg[0] == OP_READ10,
        "read flag set without a read(10) opcode latched")
    `SCU_ASSERT(a_irq_on_cmd_only, !irq || (go && item.kind == KIND_WRITE && r == R_CMD),
        "interrupt raised outside a command write")
    `SCU_ASSERT_NEXT(a_idle_holds_latch, !go,
        $stable(lba_reg) && $stable(rflag_reg) && $stable(ptr_reg),
        "latched state changed without an access")

endmodule

// ----- hdl/scsi_controller_register_model_unit.sv -----
// top level of the scsi controller register model unit
// depends on scu_pkg, scu_in_if, scu_out_if and scu_core
//
// req carries one register access per transfer: kind (read, write or dma
// done), reg_index and write_data. rsp carries one result per access:
// read_data, irq_raise and the latched cmd_opcode, sector_lba and
// read_pending as they stand after that access.
// an accepted access is held in the input register, where it is decoded and
// applied to the register file; its result is captured in the output
// register when the access moves on, which waits while rsp is stalled. one
// access per cycle is sustained while rsp does not stall; the decode
// between the input and output registers sets that figure.
// a stalled rsp holds its result; req stays ready while the input register
// is free or can move on, so one more access is buffered during a stall.
// reset clears the register file, fifo, pointer, cdb, lba and read flag and
// empties both stages.
module scsi_controller_register_model_unit import scu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    scu_in_if.sink           req,
    scu_out_if.source        rsp
);

    scu_item_t   item_reg;
    logic        in_valid_reg;
    logic        in_valid_next;
    scu_result_t result_reg;
    scu_result_t core_result;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;
    logic        req_xfer;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_xfer  = req.valid && req.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (req_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_xfer)
        begin
            item_reg <= '{kind: req.kind, reg_index: req.reg_index,
                          write_data: req.write_data};
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    scu_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (advance),
        .item   (item_reg),
        .result (core_result)
    );

    assign rsp.valid        = out_valid_reg;
    assign rsp.read_data    = result_reg.read_data;
    assign rsp.irq_raise    = result_reg.irq_raise;
    assign rsp.cmd_opcode   = result_reg.cmd_opcode;
    assign rsp.sector_lba   = result_reg.sector_lba;
    assign rsp.read_pending = result_reg.read_pending;

endmodule
